// File: src/tst_pkg.sv
// ---------------------------------------------------------------------------
// tst_pkg: shared types and constants of the timeout slot timer
// Field widths, operation and result codes, and the command word that the
// front part hands to the back part through the queue.
// ---------------------------------------------------------------------------
package tst_pkg;

    localparam int MODE_W = 2;
    localparam int DUR_W  = 32;
    localparam int TAG_W  = 8;
    localparam int SLOT_W = 3;
    localparam int KIND_W = 2;
    localparam int TS_W   = 64;
    localparam int INC_W  = 16;

    localparam int NUM_SLOTS_DEF   = 5;
    localparam int QUEUE_DEPTH_DEF = 2;

    localparam logic [INC_W-1:0] INC_RESET = 16'd100;

    localparam logic [MODE_W-1:0] MODE_TICK   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_ARM    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CANCEL = 2'd2;
    localparam logic [MODE_W-1:0] MODE_READ   = 2'd3;

    localparam logic [KIND_W-1:0] KIND_EXPIRY = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ARM    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CANCEL = 2'd2;
    localparam logic [KIND_W-1:0] KIND_TIME   = 2'd3;

    typedef struct packed {
        logic [MODE_W-1:0] op;
        logic [DUR_W-1:0]  duration;
        logic [TAG_W-1:0]  tag;
        logic [SLOT_W-1:0] idx;
        logic              idx_ok;
    } t_cmd;

endpackage

// File: src/timeout_slot_timer_core.sv
// ---------------------------------------------------------------------------
// timeout_slot_timer_core: microsecond timestamp with one-shot timeout slots
// Request words go through an intake stage and a short queue to an
// execution unit that owns the timestamp and the slot table.
// ---------------------------------------------------------------------------
// usage:
//   a request word is taken at a clock edge with start high and busy low;
//   busy is high only while the command queue is full
//   results come one per cycle on the o_ ports, marked by o_valid, and the
//   receiver must take them; o_last flags the final result of a request
//   arm, cancel and read give one result, registered first in the queue and then in the output register
//   a tick gives zero to NUM_SLOTS expiries; the execution unit does the
//   64-bit add, then the deadline compare slot by slot (a single 64-bit
//   comparator walks the table) and then a flush step that releases the
//   final expiry; every other request is done straight from idle
//   the queue absorbs requests that arrive while a tick scan runs
//   the tick increment register is written through i_cfg_we / i_cfg_wdata;
//   the user must write it only while no request is in flight; the block itself does not enforce this
//   reset clears the timestamp, frees every slot, empties the queue and
//   loads an increment of 100
// ---------------------------------------------------------------------------
module timeout_slot_timer_core #(
    parameter int NUM_SLOTS   = tst_pkg::NUM_SLOTS_DEF,
    parameter int QUEUE_DEPTH = tst_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [tst_pkg::INC_W-1:0]   i_cfg_wdata,
    input  logic                        start,
    output logic                        busy,
    input  logic [tst_pkg::MODE_W-1:0]  i_mode,
    input  logic [tst_pkg::DUR_W-1:0]   i_duration,
    input  logic [tst_pkg::TAG_W-1:0]   i_handler_tag,
    input  logic [tst_pkg::SLOT_W-1:0]  i_slot_index,
    output logic                        o_valid,
    output logic [tst_pkg::KIND_W-1:0]  o_kind,
    output logic [tst_pkg::SLOT_W-1:0]  o_slot,
    output logic                        o_ok,
    output logic [tst_pkg::TAG_W-1:0]   o_tag_out,
    output logic [tst_pkg::TS_W-1:0]    o_timestamp,
    output logic                        o_last
);
    import tst_pkg::*;

    t_cmd front_cmd;
    t_cmd queue_cmd;
    logic front_push;
    logic queue_full;
    logic queue_valid;
    logic queue_pop;

    tst_front #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_front (
        .start         (start),
        .busy          (busy),
        .i_mode        (i_mode),
        .i_duration    (i_duration),
        .i_handler_tag (i_handler_tag),
        .i_slot_index  (i_slot_index),
        .i_full        (queue_full),
        .o_push        (front_push),
        .o_cmd         (front_cmd)
    );

    tst_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .i_cmd   (front_cmd),
        .o_full  (queue_full),
        .i_pop   (queue_pop),
        .o_valid (queue_valid),
        .o_cmd   (queue_cmd)
    );

    tst_back #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_q_valid   (queue_valid),
        .i_cmd       (queue_cmd),
        .o_q_pop     (queue_pop),
        .o_valid     (o_valid),
        .o_kind      (o_kind),
        .o_slot      (o_slot),
        .o_ok        (o_ok),
        .o_tag_out   (o_tag_out),
        .o_timestamp (o_timestamp),
        .o_last      (o_last)
    );

endmodule

// File: src/tst_front.sv
// ---------------------------------------------------------------------------
// tst_front: command intake
// Takes a request word when the queue has room and classifies it into a
// command word, checking the cancel index against the slot count.
// ---------------------------------------------------------------------------
module tst_front #(
    parameter int NUM_SLOTS = tst_pkg::NUM_SLOTS_DEF
) (
    input  logic                        start,
    output logic                        busy,
    input  logic [tst_pkg::MODE_W-1:0]  i_mode,
    input  logic [tst_pkg::DUR_W-1:0]   i_duration,
    input  logic [tst_pkg::TAG_W-1:0]   i_handler_tag,
    input  logic [tst_pkg::SLOT_W-1:0]  i_slot_index,
    input  logic                        i_full,
    output logic                        o_push,
    output tst_pkg::t_cmd               o_cmd
);
    import tst_pkg::*;

    localparam logic [SLOT_W:0] SLOT_LIMIT = (SLOT_W+1)'(NUM_SLOTS);

    assign busy   = i_full;
    assign o_push = start & ~i_full;

    always_comb begin
        o_cmd.op       = i_mode;
        o_cmd.duration = i_duration;
        o_cmd.tag      = i_handler_tag;
        o_cmd.idx      = i_slot_index;
        o_cmd.idx_ok   = ({1'b0, i_slot_index} < SLOT_LIMIT);
    end

endmodule

// File: src/tst_queue.sv
// ---------------------------------------------------------------------------
// tst_queue: command queue
// Small first-in first-out buffer of command words between intake and
// execution, so that each side stalls on its own.
// ---------------------------------------------------------------------------
module tst_queue #(
    parameter int DEPTH = tst_pkg::QUEUE_DEPTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  tst_pkg::t_cmd i_cmd,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_valid,
    output tst_pkg::t_cmd o_cmd
);
    import tst_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    t_cmd             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == CNT_FULL);
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd_ptr];
    assign do_push = i_push & ~o_full;
    assign do_pop  = i_pop & o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

// File: src/tst_back.sv
// ---------------------------------------------------------------------------
// tst_back: command execution
// Holds the timestamp and the slot table, runs arm, cancel and read from
// idle and a tick as an add, a one-slot-per-cycle scan and a flush.
// ---------------------------------------------------------------------------
module tst_back #(
    parameter int NUM_SLOTS = tst_pkg::NUM_SLOTS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [tst_pkg::INC_W-1:0]   i_cfg_wdata,
    input  logic                        i_q_valid,
    input  tst_pkg::t_cmd               i_cmd,
    output logic                        o_q_pop,
    output logic                        o_valid,
    output logic [tst_pkg::KIND_W-1:0]  o_kind,
    output logic [tst_pkg::SLOT_W-1:0]  o_slot,
    output logic                        o_ok,
    output logic [tst_pkg::TAG_W-1:0]   o_tag_out,
    output logic [tst_pkg::TS_W-1:0]    o_timestamp,
    output logic                        o_last
);
    import tst_pkg::*;

    localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_SLOTS - 1);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_FLUSH = 2'd2;

    logic [INC_W-1:0]     r_inc;
    logic [TS_W-1:0]      r_now;
    logic [NUM_SLOTS-1:0] r_armed;
    logic [TS_W-1:0]      r_deadline [NUM_SLOTS];
    logic [TAG_W-1:0]     r_tag [NUM_SLOTS];
    logic [1:0]           r_state;
    logic [IDX_W-1:0]     r_idx;
    logic                 r_hold_v;
    logic [IDX_W-1:0]     r_hold_slot;
    logic [TAG_W-1:0]     r_hold_tag;

    logic                 r_out_valid;
    logic [KIND_W-1:0]    r_out_kind;
    logic [SLOT_W-1:0]    r_out_slot;
    logic                 r_out_ok;
    logic [TAG_W-1:0]     r_out_tag;
    logic                 r_out_last;

    logic                 n_out_valid;
    logic [KIND_W-1:0]    n_out_kind;
    logic [SLOT_W-1:0]    n_out_slot;
    logic                 n_out_ok;
    logic [TAG_W-1:0]     n_out_tag;
    logic                 n_out_last;

    logic                 free_found;
    logic [IDX_W-1:0]     free_idx;
    logic [IDX_W-1:0]     cancel_idx;
    logic                 scan_due;
    logic                 fire;
    logic                 arm_take;
    logic                 cancel_hit;

    // lowest free slot
    always_comb begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
            if (!r_armed[i]) begin
                free_found = 1'b1;
                free_idx   = IDX_W'(i);
            end
        end
    end

    assign cancel_idx = i_cmd.idx[IDX_W-1:0];
    assign o_q_pop    = (r_state == ST_IDLE) && i_q_valid;
    assign scan_due   = r_armed[r_idx] && (r_deadline[r_idx] < r_now);
    assign fire       = (r_state == ST_SCAN) && scan_due;
    assign arm_take   = o_q_pop && (i_cmd.op == MODE_ARM) && free_found;
    assign cancel_hit = o_q_pop && (i_cmd.op == MODE_CANCEL) && i_cmd.idx_ok;

    // a fired slot is held until the next one fires or the flush, so that the final expiry can carry last
    always_comb begin
        n_out_valid = 1'b0;
        n_out_kind  = KIND_EXPIRY;
        n_out_slot  = '0;
        n_out_ok    = 1'b1;
        n_out_tag   = '0;
        n_out_last  = 1'b1;
        unique case (r_state)
            ST_IDLE: begin
                if (i_q_valid) begin
                    unique case (i_cmd.op)
                        MODE_TICK: begin
                            n_out_valid = 1'b0;
                        end
                        MODE_ARM: begin
                            n_out_valid = 1'b1;
                            n_out_kind  = KIND_ARM;
                            n_out_slot  = free_found ? SLOT_W'(free_idx) : '0;
                            n_out_ok    = free_found;
                        end
                        MODE_CANCEL: begin
                            n_out_valid = 1'b1;
                            n_out_kind  = KIND_CANCEL;
                            n_out_slot  = i_cmd.idx;
                            n_out_ok    = i_cmd.idx_ok;
                        end
                        MODE_READ: begin
                            n_out_valid = 1'b1;
                            n_out_kind  = KIND_TIME;
                        end
                        default: begin
                            n_out_valid = 1'b0;
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                n_out_valid = fire && r_hold_v;
                n_out_slot  = SLOT_W'(r_hold_slot);
                n_out_tag   = r_hold_tag;
                n_out_last  = 1'b0;
            end
            ST_FLUSH: begin
                n_out_valid = r_hold_v;
                n_out_slot  = SLOT_W'(r_hold_slot);
                n_out_tag   = r_hold_tag;
            end
            default: begin
                n_out_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inc       <= INC_RESET;
            r_now       <= '0;
            r_armed     <= '0;
            r_state     <= ST_IDLE;
            r_idx       <= '0;
            r_hold_v    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_inc <= i_cfg_wdata;
            end
            r_out_valid <= n_out_valid;
            if (arm_take) begin
                r_armed[free_idx] <= 1'b1;
            end
            if (cancel_hit) begin
                r_armed[cancel_idx] <= 1'b0;
            end
            if (fire) begin
                r_armed[r_idx] <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (o_q_pop && (i_cmd.op == MODE_TICK)) begin
                        r_now   <= r_now + TS_W'(r_inc);
                        r_idx   <= '0;
                        r_state <= ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    if (fire) begin
                        r_hold_v <= 1'b1;
                    end
                    if (r_idx == LAST_IDX) begin
                        r_state <= ST_FLUSH;
                    end else begin
                        r_idx <= r_idx + IDX_W'(1);
                    end
                end
                ST_FLUSH: begin
                    r_hold_v <= 1'b0;
                    r_state  <= ST_IDLE;
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (arm_take) begin
            r_deadline[free_idx] <= r_now + TS_W'(i_cmd.duration);
            r_tag[free_idx]      <= i_cmd.tag;
        end
        if (fire) begin
            r_hold_slot <= r_idx;
            r_hold_tag  <= r_tag[r_idx];
        end
        r_out_kind <= n_out_kind;
        r_out_slot <= n_out_slot;
        r_out_ok   <= n_out_ok;
        r_out_tag  <= n_out_tag;
        r_out_last <= n_out_last;
    end

    assign o_valid     = r_out_valid;
    assign o_kind      = r_out_kind;
    assign o_slot      = r_out_slot;
    assign o_ok        = r_out_ok;
    assign o_tag_out   = r_out_tag;
    assign o_last      = r_out_last;
    assign o_timestamp = r_now;

`ifndef SYNTH
    a_idle_no_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> !r_hold_v)
        else $error("held expiry left over in idle");

    a_single_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_kind != KIND_EXPIRY)) |-> r_out_last)
        else $error("single answer without last");

    a_expiry_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_kind == KIND_EXPIRY)) |-> r_out_ok)
        else $error("expiry without ok");

    a_fire_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire |=> (r_armed[$past(r_idx)] == 1'b0))
        else $error("fired slot still armed");
`endif

endmodule
